// ===== hdl/pba_pkg.sv =====
// ----------------------------------------------------------------------------
// Page bitmap allocator package
// Sizes, codes, result word type and bit-search helpers.
// ----------------------------------------------------------------------------
package pba_pkg;

    // pool geometry
    localparam int NUM_PAGES      = 65536;
    localparam int RESERVED_PAGES = 1536;
    localparam int PAGE_BYTES     = 4096;

    localparam int ADDR_W      = 32;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int PAGE_W      = ADDR_W - PAGE_SHIFT;
    localparam int PAGE_ADDR_W = 28;
    localparam int COUNT_W     = 32;
    localparam int KIND_W      = 3;

    // bitmap words and summary groups (both 32 wide)
    localparam int BITS_PER_WORD = 32;
    localparam int BIT_IDX_W     = $clog2(BITS_PER_WORD);
    localparam int WORD_COUNT    = (NUM_PAGES + BITS_PER_WORD - 1) / BITS_PER_WORD;
    localparam int GROUP_RAW     = (WORD_COUNT + BITS_PER_WORD - 1) / BITS_PER_WORD;
    localparam int GROUP_IDX_W   = (GROUP_RAW <= 2) ? 1 : $clog2(GROUP_RAW);
    localparam int GROUP_COUNT   = 1 << GROUP_IDX_W;
    localparam int WORD_IDX_W    = GROUP_IDX_W + BIT_IDX_W;
    localparam int WORD_DEPTH    = GROUP_COUNT * BITS_PER_WORD;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC     = 3'd0,
        KIND_FREE      = 3'd1,
        KIND_MARK_USED = 3'd2,
        KIND_MARK_FREE = 3'd3,
        KIND_QUERY     = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SUM,
        S_MOD,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic [PAGE_ADDR_W-1:0] page_address;
        logic                   success;
        logic                   page_in_use;
        logic [COUNT_W-1:0]     allocation_total;
        logic [COUNT_W-1:0]     release_total;
    } pba_result_t;

    typedef struct packed {
        logic                     we;
        logic [WORD_IDX_W-1:0]    waddr;
        logic [BITS_PER_WORD-1:0] wdata;
        logic                     re;
        logic [WORD_IDX_W-1:0]    raddr;
    } bm_port_t;

    typedef struct packed {
        logic                     we;
        logic [GROUP_IDX_W-1:0]   waddr;
        logic [BITS_PER_WORD-1:0] wdata;
        logic                     re;
        logic [GROUP_IDX_W-1:0]   raddr;
    } sum_port_t;

    // bitmap word after reset: reserved pages and pages past the pool read as used
    function automatic logic [BITS_PER_WORD-1:0] init_word(input logic [WORD_IDX_W-1:0] w);
        logic [BITS_PER_WORD-1:0] v;
        longint unsigned          p;
        v = '0;
        for (int b = 0; b < BITS_PER_WORD; b++)
        begin
            p = longint'(w) * BITS_PER_WORD + b;
            v[b] = (p < RESERVED_PAGES) || (p >= NUM_PAGES);
        end
        return v;
    endfunction

    // lowest clear bit of a 32-bit word
    function automatic logic [BIT_IDX_W-1:0] first_zero_bit(input logic [BITS_PER_WORD-1:0] v);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int b = BITS_PER_WORD - 1; b >= 0; b--)
        begin
            if (!v[b])
            begin
                idx = BIT_IDX_W'(b);
            end
        end
        return idx;
    endfunction

    // lowest group whose words are not all full
    function automatic logic [GROUP_IDX_W-1:0] first_zero_group(input logic [GROUP_COUNT-1:0] v);
        logic [GROUP_IDX_W-1:0] idx;
        idx = '0;
        for (int g = GROUP_COUNT - 1; g >= 0; g--)
        begin
            if (!v[g])
            begin
                idx = GROUP_IDX_W'(g);
            end
        end
        return idx;
    endfunction

endpackage

// ===== hdl/pba_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// One request word: operation kind and physical byte address.
// ----------------------------------------------------------------------------
interface pba_req_if;
    import pba_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   byte_address;

    modport source (output valid, output kind, output byte_address, input ready);
    modport sink   (input valid, input kind, input byte_address, output ready);
endinterface

// ===== hdl/pba_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// One response word per request.
// ----------------------------------------------------------------------------
interface pba_rsp_if;
    import pba_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [PAGE_ADDR_W-1:0] page_address;
    logic                   success;
    logic                   page_in_use;
    logic [COUNT_W-1:0]     allocation_total;
    logic [COUNT_W-1:0]     release_total;

    modport source (output valid, output page_address, output success, output page_in_use,
                    output allocation_total, output release_total, input ready);
    modport sink   (input valid, input page_address, input success, input page_in_use,
                    input allocation_total, input release_total, output ready);
endinterface

// ===== hdl/pba_ram.sv =====
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pba_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/pba_seq.sv =====
// ----------------------------------------------------------------------------
// Allocator sequencer
// Reset sweep, first-fit search and read-modify-write of bitmap and summary.
// ----------------------------------------------------------------------------
module pba_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    pba_req_if.sink                request,
    input  logic                   slot_free,
    output logic                   result_push,
    output pba_pkg::pba_result_t   result,
    output pba_pkg::bm_port_t      bm_port,
    input  logic [31:0]            bm_rdata,
    output pba_pkg::sum_port_t     sum_port,
    input  logic [31:0]            sum_rdata
);
    import pba_pkg::*;

    seq_state_t               state_reg, state_next;
    logic [KIND_W-1:0]        kind_reg, kind_next;
    logic [WORD_IDX_W-1:0]    word_reg, word_next;
    logic [BIT_IDX_W-1:0]     bit_reg, bit_next;
    logic [WORD_IDX_W-1:0]    init_idx_reg, init_idx_next;
    logic [BITS_PER_WORD-1:0] sum_acc_reg, sum_acc_next;
    logic [GROUP_COUNT-1:0]   top_reg, top_next;
    logic [COUNT_W-1:0]       alloc_cnt_reg, alloc_cnt_next;
    logic [COUNT_W-1:0]       free_cnt_reg, free_cnt_next;
    logic [PAGE_ADDR_W-1:0]   page_addr_reg, page_addr_next;
    logic                     success_reg, success_next;
    logic                     used_reg, used_next;

    logic [PAGE_W-1:0]        req_page;
    logic                     req_in_range;
    logic [BIT_IDX_W-1:0]     alloc_bit;
    logic [BIT_IDX_W-1:0]     mod_bit;
    logic [BITS_PER_WORD-1:0] mod_mask;
    logic [BITS_PER_WORD-1:0] new_word;
    logic [BITS_PER_WORD-1:0] new_sum;
    logic [PAGE_W-1:0]        found_page;
    logic [GROUP_IDX_W-1:0]   mod_group;

    assign req_page     = request.byte_address[ADDR_W-1:PAGE_SHIFT];
    assign req_in_range = {1'b0, req_page} < (PAGE_W + 1)'(NUM_PAGES);
    assign alloc_bit    = first_zero_bit(bm_rdata);
    assign mod_bit      = (kind_reg == KIND_ALLOC) ? alloc_bit : bit_reg;
    assign mod_mask     = BITS_PER_WORD'(1) << mod_bit;
    assign found_page   = PAGE_W'({word_reg, alloc_bit});
    assign mod_group    = word_reg[WORD_IDX_W-1:BIT_IDX_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_idx_reg  <= '0;
            top_reg       <= '0;
            alloc_cnt_reg <= '0;
            free_cnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            init_idx_reg  <= init_idx_next;
            top_reg       <= top_next;
            alloc_cnt_reg <= alloc_cnt_next;
            free_cnt_reg  <= free_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        word_reg      <= word_next;
        bit_reg       <= bit_next;
        sum_acc_reg   <= sum_acc_next;
        page_addr_reg <= page_addr_next;
        success_reg   <= success_next;
        used_reg      <= used_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        word_next      = word_reg;
        bit_next       = bit_reg;
        init_idx_next  = init_idx_reg;
        sum_acc_next   = sum_acc_reg;
        top_next       = top_reg;
        alloc_cnt_next = alloc_cnt_reg;
        free_cnt_next  = free_cnt_reg;
        page_addr_next = page_addr_reg;
        success_next   = success_reg;
        used_next      = used_reg;
        new_word       = bm_rdata;
        new_sum        = sum_rdata;
        request.ready  = 1'b0;
        result_push    = 1'b0;

        bm_port.we     = 1'b0;
        bm_port.waddr  = word_reg;
        bm_port.wdata  = bm_rdata;
        bm_port.re     = 1'b0;
        bm_port.raddr  = req_page[WORD_IDX_W+BIT_IDX_W-1:BIT_IDX_W];
        sum_port.we    = 1'b0;
        sum_port.waddr = mod_group;
        sum_port.wdata = sum_rdata;
        sum_port.re    = 1'b0;
        sum_port.raddr = req_page[WORD_IDX_W+BIT_IDX_W-1:2*BIT_IDX_W];

        unique case (state_reg)
            S_INIT:
            begin
                // one bitmap word per cycle; summary word closes every 32 words
                bm_port.we    = 1'b1;
                bm_port.waddr = init_idx_reg;
                bm_port.wdata = init_word(init_idx_reg);
                sum_acc_next  = {&bm_port.wdata, sum_acc_reg[BITS_PER_WORD-1:1]};
                if (&init_idx_reg[BIT_IDX_W-1:0])
                begin
                    sum_port.we    = 1'b1;
                    sum_port.waddr = init_idx_reg[WORD_IDX_W-1:BIT_IDX_W];
                    sum_port.wdata = sum_acc_next;
                    top_next[init_idx_reg[WORD_IDX_W-1:BIT_IDX_W]] = &sum_acc_next;
                end
                init_idx_next = init_idx_reg + 1'b1;
                if (&init_idx_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                request.ready = 1'b1;
                if (request.valid)
                begin
                    kind_next      = request.kind;
                    word_next      = req_page[WORD_IDX_W+BIT_IDX_W-1:BIT_IDX_W];
                    bit_next       = req_page[BIT_IDX_W-1:0];
                    page_addr_next = '0;
                    success_next   = 1'b0;
                    used_next      = 1'b0;
                    unique case (request.kind)
                        KIND_ALLOC:
                        begin
                            if (&top_reg)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                sum_port.re    = 1'b1;
                                sum_port.raddr = first_zero_group(top_reg);
                                word_next      = {first_zero_group(top_reg), BIT_IDX_W'(0)};
                                state_next     = S_SUM;
                            end
                        end
                        KIND_FREE, KIND_MARK_USED, KIND_MARK_FREE, KIND_QUERY:
                        begin
                            if (req_in_range)
                            begin
                                bm_port.re  = 1'b1;
                                sum_port.re = 1'b1;
                                state_next  = S_MOD;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SUM:
            begin
                // summary word of the chosen group has at least one non-full word
                word_next     = {word_reg[WORD_IDX_W-1:BIT_IDX_W], first_zero_bit(sum_rdata)};
                bm_port.re    = 1'b1;
                bm_port.raddr = word_next;
                state_next    = S_MOD;
            end
            S_MOD:
            begin
                unique case (kind_reg)
                    KIND_ALLOC, KIND_MARK_USED: new_word = bm_rdata | mod_mask;
                    KIND_FREE, KIND_MARK_FREE:  new_word = bm_rdata & ~mod_mask;
                    default:                    new_word = bm_rdata;
                endcase
                new_sum = sum_rdata;
                new_sum[word_reg[BIT_IDX_W-1:0]] = &new_word;
                if (kind_reg != KIND_QUERY)
                begin
                    bm_port.we          = 1'b1;
                    bm_port.wdata       = new_word;
                    sum_port.we         = 1'b1;
                    sum_port.wdata      = new_sum;
                    top_next[mod_group] = &new_sum;
                end
                unique case (kind_reg)
                    KIND_ALLOC:
                    begin
                        success_next   = 1'b1;
                        alloc_cnt_next = alloc_cnt_reg + 1'b1;
                        page_addr_next = {found_page[PAGE_ADDR_W-PAGE_SHIFT-1:0],
                                          PAGE_SHIFT'(0)};
                    end
                    KIND_FREE:
                    begin
                        success_next  = 1'b1;
                        free_cnt_next = free_cnt_reg + 1'b1;
                    end
                    KIND_QUERY:
                    begin
                        used_next = bm_rdata[bit_reg];
                    end
                    default:
                    begin
                    end
                endcase
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    result_push = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    assign result.page_address     = page_addr_reg;
    assign result.success          = success_reg;
    assign result.page_in_use      = used_reg;
    assign result.allocation_total = alloc_cnt_reg;
    assign result.release_total    = free_cnt_reg;

    // summary changes only together with its bitmap word
    assert property (@(posedge clk) disable iff (!rst_n) sum_port.we |-> bm_port.we)
        else $error("summary write without bitmap write");

    // a group picked from the top flags must hold a non-full word
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SUM |-> sum_rdata != '1)
        else $error("picked group is full");

    // allocation must land on a clear bit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD && kind_reg == KIND_ALLOC) |-> !bm_rdata[alloc_bit])
        else $error("allocated word has no clear bit");

    // a delivered word returns the sequencer to idle
    assert property (@(posedge clk) disable iff (!rst_n) result_push |=> state_reg == S_IDLE)
        else $error("sequencer did not return to idle");

endmodule

// ===== hdl/page_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// Page bitmap allocator
// First-fit physical page allocator over a one-bit-per-page bitmap. After
// reset the block runs a clearing pass (one bitmap word per cycle,
// GROUP_COUNT*32 words) before it takes its first request. Each request
// word yields exactly one response word. An alloc steps the sequencer through
// accept with top-flag pick, summary word read, bitmap word read-modify-write
// and response load; free, mark and query read both memories at accept and
// skip the summary step, and out-of-range or unknown requests, or an alloc
// with every group full, go straight from accept to response load. The steps
// follow from the two registered memory reads in series: a summary memory
// with one full-flag per bitmap word and the bitmap memory itself. A response
// waits in an output register so the next request is accepted while it is
// still pending; a stalled response holds the sequencer in its load state.
// ----------------------------------------------------------------------------
module page_bitmap_allocator (
    input  logic      clk,
    input  logic      rst_n,
    pba_req_if.sink   request,
    pba_rsp_if.source response
);
    import pba_pkg::*;

    bm_port_t                 bm_port;
    sum_port_t                sum_port;
    logic [BITS_PER_WORD-1:0] bm_rdata;
    logic [BITS_PER_WORD-1:0] sum_rdata;
    pba_result_t              result;
    logic                     result_push;
    logic                     slot_free;

    // response holding register
    logic                     rsp_valid_reg, rsp_valid_next;
    pba_result_t              rsp_data_reg, rsp_data_next;

    // usage bitmap: bit b of word w is page w*32+b, 1 = in use
    pba_ram #(
        .DEPTH (WORD_DEPTH),
        .WIDTH (BITS_PER_WORD)
    ) u_bitmap (
        .clk   (clk),
        .we    (bm_port.we),
        .waddr (bm_port.waddr),
        .wdata (bm_port.wdata),
        .re    (bm_port.re),
        .raddr (bm_port.raddr),
        .rdata (bm_rdata)
    );

    // summary: bit j of group g set when bitmap word g*32+j is full
    pba_ram #(
        .DEPTH (GROUP_COUNT),
        .WIDTH (BITS_PER_WORD)
    ) u_summary (
        .clk   (clk),
        .we    (sum_port.we),
        .waddr (sum_port.waddr),
        .wdata (sum_port.wdata),
        .re    (sum_port.re),
        .raddr (sum_port.raddr),
        .rdata (sum_rdata)
    );

    pba_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (request),
        .slot_free   (slot_free),
        .result_push (result_push),
        .result      (result),
        .bm_port     (bm_port),
        .bm_rdata    (bm_rdata),
        .sum_port    (sum_port),
        .sum_rdata   (sum_rdata)
    );

    // the slot takes a new word when empty or being drained this cycle
    assign slot_free = !rsp_valid_reg || response.ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (result_push)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = result;
        end
        else if (response.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign response.valid            = rsp_valid_reg;
    assign response.page_address     = rsp_data_reg.page_address;
    assign response.success          = rsp_data_reg.success;
    assign response.page_in_use      = rsp_data_reg.page_in_use;
    assign response.allocation_total = rsp_data_reg.allocation_total;
    assign response.release_total    = rsp_data_reg.release_total;

endmodule
